// ----- rtl/tcre_pkg.sv -----
`default_nettype none

package tcre_pkg;

    // Default output queue depth in bytes.
    localparam int QUEUE_DEPTH_DEF = 1024;

    // Host command characters.
    localparam logic [7:0] C_XOFF = 8'd19;
    localparam logic [7:0] C_XON  = 8'd17;
    localparam logic [7:0] C_STX  = 8'd2;
    localparam logic [7:0] C_SOH  = 8'd1;
    localparam logic [7:0] C_R    = 8'd82;
    localparam logic [7:0] C_S    = 8'd83;
    localparam logic [7:0] C_M    = 8'd77;
    localparam logic [7:0] C_C    = 8'd67;
    localparam logic [7:0] C_D    = 8'd68;
    localparam logic [7:0] C_L    = 8'd76;

    // Marker for an empty command history slot.
    localparam logic [8:0] NO_BYTE = 9'h1FF;

    // Report byte fields.
    localparam logic [7:0] BIT7      = 8'h80;
    localparam logic [7:0] MODE_BITS = 8'h40;
    localparam logic [7:0] NOT_NEAR  = 8'h04;
    localparam logic [7:0] ALL_ONES  = 8'hFF;

    // Coordinate scaling.
    localparam logic [9:0]  X_ORIGIN      = 10'd32;
    localparam logic [11:0] Y_REMOTE_BASE = 12'd2100;
    localparam logic [11:0] Y_TABLET_BASE = 12'd2200;
    localparam logic [5:0]  X_SCALE       = 6'd55;
    localparam logic [8:0]  Y_SCALE       = 9'd275;
    localparam logic [15:0] RECIP3        = 16'd43691;
    localparam int          RECIP3_SHIFT  = 17;

    // Stage enables for the report arithmetic.
    typedef struct packed {
        logic stage1_en;
        logic stage2_en;
    } t_rpt_ctl;

endpackage

`default_nettype wire

// ----- rtl/tcre_queue_mem.sv -----
`default_nettype none

module tcre_queue_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [7:0]    i_wdata,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Single port: a write or a registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/tcre_report.sv -----
`default_nettype none

module tcre_report (
    input  wire logic               i_clk,
    input  wire tcre_pkg::t_rpt_ctl i_ctl,
    input  wire logic               i_remote,
    input  wire logic               i_near,
    input  wire logic [9:0]         i_pen_x,
    input  wire logic [8:0]         i_pen_y,
    output logic      [11:0]        o_ux,
    output logic      [11:0]        o_uy
);

    import tcre_pkg::*;

    logic [9:0]  w_dx;
    logic        w_xneg;
    logic [15:0] w_px;
    logic [17:0] w_py;
    logic [11:0] w_y5;
    logic [11:0] w_rx;
    logic [11:0] w_ry;
    logic [29:0] w_qx_full;
    logic [29:0] w_qy_full;
    logic [11:0] w_qx;
    logic [11:0] w_qy;
    logic [11:0] w_tx;
    logic [11:0] w_ty;

    logic [12:0] r_nx;
    logic [13:0] r_ny;
    logic [11:0] r_rx;
    logic [11:0] r_ry;
    logic        r_remote;
    logic        r_near;
    logic        r_xneg;
    logic [11:0] r_ux;
    logic [11:0] r_uy;

    // First stage: offsets, scale products and the remote-mode values.
    assign w_dx   = i_pen_x - X_ORIGIN;
    assign w_xneg = i_pen_x < X_ORIGIN;
    assign w_px   = 16'(X_SCALE) * 16'(w_dx);
    assign w_py   = 18'(Y_SCALE) * 18'(i_pen_y);
    assign w_y5   = 12'({i_pen_y, 2'b00}) + 12'(i_pen_y);
    assign w_rx   = w_xneg ? 12'd0 : {1'b0, w_dx, 1'b0};
    assign w_ry   = Y_REMOTE_BASE - {w_y5[11:1], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_ctl.stage1_en) begin
            r_nx     <= w_px[15:3];
            r_ny     <= w_py[17:4];
            r_rx     <= w_rx;
            r_ry     <= w_ry;
            r_remote <= i_remote;
            r_near   <= i_near;
            r_xneg   <= w_xneg;
        end
    end

    // Second stage: division by three through a reciprocal product.
    assign w_qx_full = 30'(r_nx) * 30'(RECIP3);
    assign w_qy_full = 30'(r_ny) * 30'(RECIP3);
    assign w_qx      = w_qx_full[RECIP3_SHIFT +: 12];
    assign w_qy      = w_qy_full[RECIP3_SHIFT +: 12];
    assign w_tx      = r_xneg ? 12'd0 : w_qx;
    assign w_ty      = Y_TABLET_BASE - w_qy;

    always_ff @(posedge i_clk) begin
        if (i_ctl.stage2_en) begin
            if (!r_near) begin
                r_ux <= 12'd0;
                r_uy <= 12'd0;
            end else if (r_remote) begin
                r_ux <= r_rx;
                r_uy <= r_ry;
            end else begin
                r_ux <= w_tx;
                r_uy <= w_ty;
            end
        end
    end

    assign o_ux = r_ux;
    assign o_uy = r_uy;

endmodule

`default_nettype wire

// ----- rtl/tablet_command_and_report_engine_core.sv -----
// Tablet command and report engine.
// Input channel (i_in_valid / o_in_stall): one transaction per host request.
// A write (i_req_type 0) hands over a command byte; a read (i_req_type 1)
// pops one byte from the output queue when output is enabled and it is not
// empty, first queueing a report in suppressed mode if the pen state changed.
// Output channel (o_out_valid / i_out_stall): exactly one transaction per
// request; o_read_valid is 1 when a read popped a byte, else o_read_byte is 0.
// Sequence: after acceptance, the report arithmetic states S_CALC1 and
// S_CALC2, then S_PUSH with one byte write per queued byte (0 to 6) into
// the single-port queue memory plus a step that closes the push phase,
// S_POP for the read and S_DONE to load the output register. A new request
// is accepted only when the last one is done, in the cycle after its result
// is loaded.
// While the receiver stalls, the finished result holds in the output
// register; a following request runs up to the output and then waits.
// Reset clears the queue pointers and all mode state; the queue memory
// itself needs no clearing, since only written entries are ever popped.

`default_nettype none

module tablet_command_and_report_engine_core #(
    parameter int QUEUE_DEPTH = tcre_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_host_byte,
    input  wire logic [9:0] i_pen_x,
    input  wire logic [8:0] i_pen_y,
    input  wire logic       i_pen_left,
    input  wire logic       i_pen_middle,
    input  wire logic       i_pen_right,
    input  wire logic       i_pen_near,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_read_valid,
    output logic [7:0]      o_read_byte
);

    import tcre_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC1 = 3'd1;
    localparam logic [2:0] S_CALC2 = 3'd2;
    localparam logic [2:0] S_PUSH  = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // What follows the echo byte in the queue.
    localparam logic [1:0] TK_NONE   = 2'd0;
    localparam logic [1:0] TK_REPORT = 2'd1;
    localparam logic [1:0] TK_RESET  = 2'd2;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        f_next = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Latched request.
    logic          r_req;
    logic [7:0]    r_byte;
    logic [9:0]    r_x;
    logic [8:0]    r_y;
    logic [2:0]    r_btn;
    logic          r_near;

    // Control state.
    logic [2:0]    r_state,    n_state;
    logic [AW-1:0] r_head,     n_head;
    logic [AW-1:0] r_tail,     n_tail;
    logic [8:0]    r_prev,     n_prev;
    logic [8:0]    r_prev2,    n_prev2;
    logic          r_remote,   n_remote;
    logic          r_supp,     n_supp;
    logic          r_oe,       n_oe;
    logic [9:0]    r_last_x,   n_last_x;
    logic [8:0]    r_last_y,   n_last_y;
    logic [2:0]    r_last_btn, n_last_btn;
    logic          r_last_nr,  n_last_nr;
    logic          r_force,    n_force;
    logic          r_has_echo, n_has_echo;
    logic [1:0]    r_kind,     n_kind;
    logic [2:0]    r_idx,      n_idx;
    logic          r_rd,       n_rd;
    logic          r_out_valid, n_out_valid;
    logic          r_out_rv,   n_out_rv;
    logic [7:0]    r_out_byte, n_out_byte;

    logic          w_in_acc;
    logic [AW-1:0] w_head_next;
    logic          w_full;
    logic [2:0]    w_total;
    logic [2:0]    w_pidx;
    logic [7:0]    w_rpt_byte;
    logic [7:0]    w_push_byte;
    logic          w_mem_we;
    logic          w_mem_re;
    logic [AW-1:0] w_mem_addr;
    logic [7:0]    w_rdata;
    logic [11:0]   w_ux;
    logic [11:0]   w_uy;
    logic          w_changed;
    t_rpt_ctl      w_rpt_ctl;

    assign w_in_acc = i_in_valid && (r_state == S_IDLE);

    // Capture the request on acceptance.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req  <= i_req_type;
            r_byte <= i_host_byte;
            r_x    <= i_pen_x;
            r_y    <= i_pen_y;
            r_btn  <= {i_pen_left, i_pen_middle, i_pen_right};
            r_near <= i_pen_near;
        end
    end

    // Report arithmetic runs in the calculation states S_CALC1 and S_CALC2.
    assign w_rpt_ctl.stage1_en = (r_state == S_CALC1);
    assign w_rpt_ctl.stage2_en = (r_state == S_CALC2);

    tcre_report u_report (
        .i_clk    (i_clk),
        .i_ctl    (w_rpt_ctl),
        .i_remote (r_remote),
        .i_near   (r_near),
        .i_pen_x  (r_x),
        .i_pen_y  (r_y),
        .o_ux     (w_ux),
        .o_uy     (w_uy)
    );

    // Byte to push at the current sequence index.
    assign w_total = {2'b00, r_has_echo} + ((r_kind == TK_NONE) ? 3'd0 : 3'd5);
    assign w_pidx  = r_idx - {2'b00, r_has_echo};

    always_comb begin
        case (w_pidx)
            3'd0:    w_rpt_byte = BIT7 | MODE_BITS | {2'b00, r_btn, 3'b000}
                                  | (r_near ? 8'h00 : NOT_NEAR);
            3'd1:    w_rpt_byte = BIT7 | {2'b00, w_ux[5:0]};
            3'd2:    w_rpt_byte = BIT7 | {2'b00, w_ux[11:6]};
            3'd3:    w_rpt_byte = BIT7 | {2'b00, w_uy[5:0]};
            3'd4:    w_rpt_byte = BIT7 | {2'b00, w_uy[11:6]};
            default: w_rpt_byte = 8'h00;
        endcase
    end

    assign w_push_byte = (r_has_echo && (r_idx == 3'd0)) ? (r_byte | BIT7) :
                         (r_kind == TK_RESET) ? ALL_ONES : w_rpt_byte;

    // Queue memory access: pushes write at the head, the pop of a read request
    // reads the tail.
    assign w_head_next = f_next(r_head);
    assign w_full      = (w_head_next == r_tail);
    assign w_mem_we    = (r_state == S_PUSH) && (r_idx != w_total) && !w_full;
    assign w_mem_re    = (r_state == S_POP) && r_req && r_oe && (r_head != r_tail);
    assign w_mem_addr  = w_mem_we ? r_head : r_tail;

    tcre_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (w_push_byte),
        .o_rdata (w_rdata)
    );

    assign w_changed = r_force || (r_x != r_last_x) || (r_y != r_last_y)
                       || (r_btn != r_last_btn) || (r_near != r_last_nr);

    // Sequencer and command decode.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_prev      = r_prev;
        n_prev2     = r_prev2;
        n_remote    = r_remote;
        n_supp      = r_supp;
        n_oe        = r_oe;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_last_btn  = r_last_btn;
        n_last_nr   = r_last_nr;
        n_force     = r_force;
        n_has_echo  = r_has_echo;
        n_kind      = r_kind;
        n_idx       = r_idx;
        n_rd        = r_rd;
        n_out_valid = r_out_valid;
        n_out_rv    = r_out_rv;
        n_out_byte  = r_out_byte;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CALC1;
                end
            end
            S_CALC1: begin
                n_state = S_CALC2;
            end
            S_CALC2: begin
                n_has_echo = 1'b0;
                n_kind     = TK_NONE;
                n_idx      = 3'd0;
                n_state    = S_PUSH;
                if (!r_req) begin
                    if (r_byte == C_XOFF) begin
                        n_oe = 1'b0;
                    end else if (r_byte == C_XON) begin
                        n_oe = 1'b1;
                    end else begin
                        n_has_echo = 1'b1;
                        if ((r_byte == C_STX) && r_remote) begin
                            n_kind = TK_REPORT;
                        end else if (r_prev2 == {1'b0, C_SOH}) begin
                            if ((r_prev == {1'b0, C_R}) && (r_byte == C_S)) begin
                                n_remote = 1'b0;
                                n_supp   = 1'b0;
                                n_force  = 1'b1;
                                n_oe     = 1'b1;
                                n_kind   = TK_RESET;
                            end else if ((r_prev == {1'b0, C_R}) && (r_byte == C_M)) begin
                                n_remote = 1'b1;
                                n_supp   = 1'b0;
                            end else if (r_prev == {1'b0, C_S}) begin
                                n_remote = 1'b0;
                                n_supp   = 1'b1;
                            end else if ((r_prev == {1'b0, C_C}) || (r_prev == {1'b0, C_D})
                                         || (r_prev == {1'b0, C_L})) begin
                                n_remote = 1'b0;
                                n_supp   = 1'b0;
                            end
                        end
                    end
                    n_prev2 = r_prev;
                    n_prev  = {1'b0, r_byte};
                end else if (r_supp && r_oe && w_changed) begin
                    n_kind     = TK_REPORT;
                    n_last_x   = r_x;
                    n_last_y   = r_y;
                    n_last_btn = r_btn;
                    n_last_nr  = r_near;
                    n_force    = 1'b0;
                end
            end
            S_PUSH: begin
                if (r_idx == w_total) begin
                    n_state = S_POP;
                end else begin
                    if (!w_full) begin
                        n_head = w_head_next;
                    end
                    n_idx = r_idx + 3'd1;
                end
            end
            S_POP: begin
                n_rd = w_mem_re;
                if (w_mem_re) begin
                    n_tail = f_next(r_tail);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_rv    = r_rd;
                    n_out_byte  = r_rd ? w_rdata : 8'h00;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_prev      <= NO_BYTE;
            r_prev2     <= NO_BYTE;
            r_remote    <= 1'b0;
            r_supp      <= 1'b0;
            r_oe        <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_last_btn  <= '0;
            r_last_nr   <= 1'b0;
            r_force     <= 1'b1;
            r_has_echo  <= 1'b0;
            r_kind      <= TK_NONE;
            r_idx       <= '0;
            r_rd        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_prev      <= n_prev;
            r_prev2     <= n_prev2;
            r_remote    <= n_remote;
            r_supp      <= n_supp;
            r_oe        <= n_oe;
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
            r_last_btn  <= n_last_btn;
            r_last_nr   <= n_last_nr;
            r_force     <= n_force;
            r_has_echo  <= n_has_echo;
            r_kind      <= n_kind;
            r_idx       <= n_idx;
            r_rd        <= n_rd;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out_rv   <= n_out_rv;
        r_out_byte <= n_out_byte;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_valid = r_out_rv;
    assign o_read_byte  = r_out_byte;

endmodule

`default_nettype wire

// ----- rtl/tcre_checker.sv -----
`default_nettype none

module tcre_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_read_valid,
    input wire logic [7:0] o_read_byte
);

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result transaction dropped while stalled");

    // Every queued byte carries bit 7, so a popped byte must too.
    a_bit7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_valid |-> o_read_byte[7])
        else $error("popped byte without bit 7");

    // A result without a popped byte reads as zero.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_valid |-> (o_read_byte == 8'h00))
        else $error("nonzero byte on an empty result");

    // An accepted request keeps the input side busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted twice in a row");

    // Reset leaves no result pending and the input side ready.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state not cleared by reset");

endmodule

bind tablet_command_and_report_engine_core tcre_checker u_tcre_checker (.*);

`default_nettype wire
